// File: sv/sidec_pkg.sv
// Shared types, constants and double-dabble helpers for the signed integer
// to decimal ASCII unit. No dependencies.
package sidec_pkg;

  localparam int ValueW       = 32;
  localparam int DigitCount   = 10;
  localparam int BcdW         = 4 * DigitCount;
  localparam int BitsPerStage = 4;
  localparam int DabbleStages = ValueW / BitsPerStage;
  localparam int DigitIdxW    = $clog2(DigitCount);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  typedef struct packed {
    logic              neg;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dab_word_t;

  // One double-dabble step: bias every digit of 5 or more, then shift in b.
  function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                  input logic b);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DigitCount; d++) begin
      if (adj[4*d +: 4] >= 4'd5) adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
    end
    return {adj[BcdW-2:0], b};
  endfunction

  // Consume the next BitsPerStage bits of the binary value, MSB first.
  function automatic dab_word_t dabble_stage(input dab_word_t w);
    dab_word_t r;
    r = w;
    for (int s = 0; s < BitsPerStage; s++) begin
      r.bcd = dabble_step(r.bcd, r.bin[ValueW-1]);
      r.bin = {r.bin[ValueW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: sv/sidec_if.sv
// Valid/ready channels of the decimal ASCII unit: integer in, characters out.
// Depends on sidec_pkg for field widths.
interface sidec_value_if;
  logic                              valid;
  logic                              ready;
  logic signed [sidec_pkg::ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidec_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: sv/sidec_bcd_pipe.sv
// Binary to BCD conversion, one register stage per group of magnitude bits.
// Depends on sidec_pkg (dab_word_t, dabble_stage).
module sidec_bcd_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sidec_pkg::dab_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sidec_pkg::dab_word_t out_word
);
  import sidec_pkg::*;

  dab_word_t stg   [DabbleStages];
  logic      v     [DabbleStages];
  dab_word_t feed_w[DabbleStages];
  logic      feed_v[DabbleStages];
  logic      rdy   [DabbleStages+1];

  assign rdy[DabbleStages] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v[DabbleStages-1];
  assign out_word  = stg[DabbleStages-1];

  for (genvar k = 0; k < DabbleStages; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign feed_w[k] = in_word;
      assign feed_v[k] = in_valid;
    end else begin : g_body
      assign feed_w[k] = stg[k-1];
      assign feed_v[k] = v[k-1];
    end

    // a stage takes a word when it is empty or its own word moves on
    assign rdy[k] = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= feed_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && feed_v[k]) begin
        stg[k] <= dabble_stage(feed_w[k]);
      end
    end
  end

endmodule

// File: sv/signed_int_to_decimal_ascii_unit.sv
// Top level: signed 32-bit integer to decimal ASCII characters, MSB first.
// Depends on sidec_pkg, sidec_if.sv and sidec_bcd_pipe.
//
//   channel  dir  payload                       word
//   num      in   value[31:0] signed            one integer
//   txt      out  text_char[7:0], last_char     one character
//
// An integer passes a magnitude stage, eight BCD stages and a digit-count
// stage before the serializer takes it.
// The character serializer emits one word per cycle while txt is free: an
// integer holds it for 1 to 11 words (sign plus significant digits), which sets the rate.
// Synchronous reset empties every stage and the output register.
// A stall on txt backs up through the stages without loss; bubbles are filled.
module signed_int_to_decimal_ascii_unit (
  input logic         clk,
  input logic         rst,
  sidec_value_if.sink num,
  sidec_char_if.source txt
);
  import sidec_pkg::*;

  // magnitude stage
  logic      mag_v;
  dab_word_t mag_word;
  logic      mag_ready;
  logic      pipe_in_ready;

  // BCD pipe output
  logic      pipe_v;
  dab_word_t pipe_word;
  logic      pipe_ready;

  // digit-count stage
  logic                 cnt_v;
  logic                 cnt_neg;
  logic [BcdW-1:0]      cnt_bcd;
  logic [DigitIdxW-1:0] cnt_hi;
  logic [DigitIdxW-1:0] hi_next;

  // serializer and output register
  logic                 busy;
  logic                 sgn_pend;
  logic [DigitIdxW-1:0] idx;
  logic [BcdW-1:0]      ser_bcd;
  logic                 ser_load;
  logic                 out_free;
  logic                 emit;
  logic [3:0]           digit;
  logic [7:0]           char_next;
  logic                 last_next;
  logic                 o_valid;
  logic [7:0]           o_char;
  logic                 o_last;

  assign mag_ready = !mag_v || pipe_in_ready;
  assign num.ready = mag_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_v <= 1'b0;
    end else if (mag_ready) begin
      mag_v <= num.valid;
    end
  end

  // the 32-bit unsigned magnitude also covers the most negative value
  always_ff @(posedge clk) begin
    if (mag_ready && num.valid) begin
      mag_word.neg <= num.value[ValueW-1];
      mag_word.bcd <= '0;
      mag_word.bin <= num.value[ValueW-1] ? (~num.value) + 1'b1 : num.value;
    end
  end

  sidec_bcd_pipe u_bcd_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mag_v),
    .in_ready  (pipe_in_ready),
    .in_word   (mag_word),
    .out_valid (pipe_v),
    .out_ready (pipe_ready),
    .out_word  (pipe_word)
  );

  // highest nonzero digit; zero still yields one digit
  always_comb begin
    hi_next = '0;
    for (int d = 1; d < DigitCount; d++) begin
      if (pipe_word.bcd[4*d +: 4] != 4'd0) hi_next = DigitIdxW'(d);
    end
  end

  assign pipe_ready = !cnt_v || ser_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_v <= 1'b0;
    end else if (pipe_ready) begin
      cnt_v <= pipe_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready && pipe_v) begin
      cnt_neg <= pipe_word.neg;
      cnt_bcd <= pipe_word.bcd;
      cnt_hi  <= hi_next;
    end
  end

  assign out_free  = !o_valid || txt.ready;
  assign emit      = busy && out_free;
  assign last_next = !sgn_pend && (idx == '0);
  assign ser_load  = !busy || (emit && last_next);
  assign digit     = ser_bcd[{idx, 2'b00} +: 4];
  assign char_next = sgn_pend ? CharMinus : CharZero + {4'b0000, digit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sgn_pend <= 1'b0;
      idx      <= '0;
    end else if (ser_load) begin
      busy     <= cnt_v;
      sgn_pend <= cnt_v && cnt_neg;
      idx      <= cnt_v ? cnt_hi : '0;
    end else if (emit) begin
      // drop the sign first, then walk the digits down
      if (sgn_pend) begin
        sgn_pend <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load && cnt_v) begin
      ser_bcd <= cnt_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_char <= char_next;
      o_last <= last_next;
    end
  end

  assign txt.valid     = o_valid;
  assign txt.text_char = o_char;
  assign txt.last_char = o_last;

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_char == CharMinus) |-> !o_last)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_char == CharMinus) ||
                ((o_char >= CharZero) && (o_char <= CharZero + 8'd9)))
    else $error("character is neither a digit nor a minus sign");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= DigitIdxW'(DigitCount - 1))
    else $error("digit index beyond the BCD word");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    o_valid && txt.ready && (o_char == CharMinus) |=> o_valid && (o_char != CharMinus))
    else $error("minus sign not followed at once by a digit");

endmodule

// File: verif/sidec_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the decimal ASCII unit: predicts the characters of each
// accepted integer and checks the character words. Depends on sidec_pkg.
package sidec_tb_pkg;

  import sidec_pkg::*;

  class char_scoreboard;

    localparam int DecBase = 10;

    // {text_char, last_char}, oldest first
    bit [8:0] expected_chars[$];
    int       fails;

    function void note_value(logic signed [ValueW-1:0] value);
      logic [ValueW:0] magnitude;
      bit   [7:0]      digit_chars[$];
      bit              neg;
      neg = value[ValueW-1];
      // widen before negating so the most negative value keeps its magnitude
      magnitude = neg ? ((ValueW+1)'(~value) + 1'b1) : {1'b0, value};
      do begin
        digit_chars.push_front(CharZero + 8'(magnitude % DecBase));
        magnitude = magnitude / DecBase;
      end while (magnitude != 0);
      if (neg) expected_chars.push_back({CharMinus, 1'b0});
      foreach (digit_chars[k]) begin
        expected_chars.push_back({digit_chars[k], k == digit_chars.size() - 1});
      end
    endfunction

    function void check_char(logic [7:0] text_char, logic last_char);
      bit [8:0] want;
      if (expected_chars.size() == 0) begin
        $error("unexpected word: text_char %0d last_char %0d", text_char, last_char);
        fails++;
        return;
      end
      want = expected_chars.pop_front();
      if (text_char !== want[8:1]) begin
        $error("text_char mismatch: expected %0d actual %0d", want[8:1], text_char);
        fails++;
      end
      if (last_char !== want[0]) begin
        $error("last_char mismatch: expected %0d actual %0d", want[0], last_char);
        fails++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

  endclass

endpackage

// File: verif/tb_signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Testbench top for signed_int_to_decimal_ascii_unit: drives integers,
// stalls the character side and checks every word. Depends on sidec_pkg,
// sidec_if.sv, sidec_tb_pkg and the unit.
module tb_signed_int_to_decimal_ascii_unit;

  import sidec_pkg::*;
  import sidec_tb_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 30;

  logic clk = 1'b0;
  logic rst;

  sidec_value_if num_ch ();
  sidec_char_if  txt_ch ();

  signed_int_to_decimal_ascii_unit i_dut (
    .clk (clk),
    .rst (rst),
    .num (num_ch),
    .txt (txt_ch)
  );

  char_scoreboard sb = new;

  bit calm;
  bit hold_req;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly values of a random digit count, so short and long texts both occur.
  function automatic logic signed [ValueW-1:0] rand_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    bit     neg;
    if ($urandom_range(0, 9) < 2) return $urandom;
    ndig = $urandom_range(1, 10);
    neg  = 1'($urandom_range(0, 1));
    lo   = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi   = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
    mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return neg ? ValueW'(-mag) : ValueW'(mag);
  endfunction

  task automatic send_value(logic signed [ValueW-1:0] value);
    int gap;
    num_ch.valid <= 1'b1;
    num_ch.value <= value;
    @(posedge clk);
    while (!num_ch.ready) @(posedge clk);
    sb.note_value(value);
    gap = pick_gap();
    if (gap > 0) begin
      num_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic hold_send();
    num_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // character side: random stalls, one long hold-off on request
  initial begin
    txt_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        txt_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        txt_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        txt_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && txt_ch.valid && txt_ch.ready) sb.check_char(txt_ch.text_char, txt_ch.last_char);
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((num_ch.valid && num_ch.ready) || (txt_ch.valid && txt_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL signed_int_to_decimal_ascii_unit");
        $finish;
      end
    end
  end

  initial begin
    logic signed [ValueW-1:0] corner_values[$];
    corner_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999999999, 1000000000,
                      -1000000000, 2147483647, -2147483647, 32'sh80000000,
                      32'sh55555555, 32'shAAAAAAAA, 123456789, -987654321};
    calm         = 1'b0;
    hold_req     = 1'b0;
    rst          <= 1'b1;
    num_ch.valid <= 1'b0;
    num_ch.value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_values[i]) send_value(corner_values[i]);
    hold_send();
    wait_drained();

    // back-to-back with no stalls inserted by the testbench
    calm = 1'b1;
    repeat (20) send_value(rand_value());
    calm = 1'b0;

    // fill the unit while the character side holds off
    hold_req = 1'b1;
    repeat (40) begin
      num_ch.valid <= 1'b1;
      num_ch.value <= rand_value();
      @(posedge clk);
      while (!num_ch.ready) @(posedge clk);
      sb.note_value(num_ch.value);
    end
    hold_send();
    wait_drained();

    repeat (140) send_value(rand_value());
    hold_send();
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    if (sb.fails == 0) begin
      $display("PASS signed_int_to_decimal_ascii_unit");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_unit");
    end
    $finish;
  end

endmodule
